// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Command codes, status codes and sequencer states of the deque core; the
// status codes are shared with its checker.
// ----------------------------------------------------------------------------
package deq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REVERSE    = 3'd4,
		CMD_SORT       = 3'd5,
		CMD_STATUS     = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DONE,
		S_REV_RA,
		S_REV_RB,
		S_REV_WA,
		S_REV_WB,
		S_SRT_START,
		S_SRT_LOAD,
		S_SRT_CMP,
		S_SRT_LAST
	} state_t;

endpackage

// ===== rtl/double_ended_queue_with_sort_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_sort_core
// Bounded double-ended queue of signed words in a circular RAM, with
// in-place reverse and ascending sort.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_ channel; each transaction yields exactly one
// result transaction on the m_ channel. The block works on one command at a
// time: s_tready is high only while the sequencer is idle.
// Push, pop, status and the overflow and underflow cases go from idle to
// S_DONE, which loads the result once the output register is free; only
// then does the block return to idle for the next command. A pop that leaves
// words behind reads the new end word from the RAM when it is accepted.
// Reverse makes four RAM accesses per swapped pair through the single read
// and single write port.
// Sort is a bubble sort that carries the running maximum in a register, with
// one RAM read and one write per compare.
// Reset empties the queue; the RAM contents are not cleared and never need
// to be, since only live entries are read.
// The result sits in an output register. While the receiver stalls, the next
// command may still be accepted and executed, but its result waits until the
// previous one has been taken.
// ----------------------------------------------------------------------------
module double_ended_queue_with_sort_core #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int IN_W  = ((3 + DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((3 * DATA_WIDTH + CW + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// command, push_value
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// popped_value, status, count, is_empty, front_value, back_value
	output logic [OUT_W-1:0] m_tdata
);

	localparam int DW = DATA_WIDTH;
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

	deq_pkg::state_t  state_q, state_d;
	deq_pkg::cmd_t    cmd;
	deq_pkg::status_t status_q;

	logic [DW-1:0] push_value;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [DW-1:0] front_q, back_q, popped_q, tmp_q;
	logic [AW-1:0] idx_l_q, idx_r_q;
	logic          fix_front_q, fix_back_q, first_pass_q;
	logic          m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic          accept, full, two_plus, out_free, greater;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_log, wr_log, rd_addr, wr_addr, head_next;
	logic [DW-1:0] wr_data, rd_data, min_val, max_val;
	logic [DW-1:0] front_sel, back_sel;
	logic          empty;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	assign cmd        = deq_pkg::cmd_t'(s_tdata[2:0]);
	assign push_value = s_tdata[3 +: DW];
	assign s_tready   = (state_q == deq_pkg::S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign full       = (count_q == CW'(DEPTH));
	assign two_plus   = (count_q >= CW'(2));
	assign out_free   = !m_tvalid_q || m_tready;

	assign rd_addr   = wrap_add(head_q, rd_log);
	assign wr_addr   = wrap_add(head_q, wr_log);
	assign head_next = wrap_add(head_q, AW'(1));

	assign greater = $signed(tmp_q) > $signed(rd_data);
	assign min_val = greater ? rd_data : tmp_q;
	assign max_val = greater ? tmp_q : rd_data;

	// A pop that leaves words behind picks up the new end word here.
	assign empty     = (count_q == '0);
	assign front_sel = empty ? '0 : (fix_front_q ? rd_data : front_q);
	assign back_sel  = empty ? '0 : (fix_back_q ? rd_data : back_q);

	deq_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_log  = '0;
		wr_en   = 1'b0;
		wr_log  = '0;
		wr_data = tmp_q;
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (accept) begin
					state_d = deq_pkg::S_DONE;
					case (cmd)
						deq_pkg::CMD_PUSH_FRONT: begin
							wr_en   = !full;
							wr_log  = AW'(DEPTH - 1);
							wr_data = push_value;
						end
						deq_pkg::CMD_PUSH_BACK: begin
							wr_en   = !full;
							wr_log  = count_q[AW-1:0];
							wr_data = push_value;
						end
						deq_pkg::CMD_POP_FRONT: begin
							rd_en  = two_plus;
							rd_log = AW'(1);
						end
						deq_pkg::CMD_POP_BACK: begin
							rd_en  = two_plus;
							rd_log = count_q[AW-1:0] - AW'(2);
						end
						deq_pkg::CMD_REVERSE: begin
							if (two_plus) begin
								state_d = deq_pkg::S_REV_RA;
							end
						end
						deq_pkg::CMD_SORT: begin
							if (two_plus) begin
								state_d = deq_pkg::S_SRT_START;
							end
						end
						default: begin
						end
					endcase
				end
			end
			deq_pkg::S_REV_RA: begin
				rd_en   = 1'b1;
				rd_log  = idx_l_q;
				state_d = deq_pkg::S_REV_RB;
			end
			deq_pkg::S_REV_RB: begin
				rd_en   = 1'b1;
				rd_log  = idx_r_q;
				state_d = deq_pkg::S_REV_WA;
			end
			deq_pkg::S_REV_WA: begin
				wr_en   = 1'b1;
				wr_log  = idx_l_q;
				wr_data = rd_data;
				state_d = deq_pkg::S_REV_WB;
			end
			deq_pkg::S_REV_WB: begin
				wr_en  = 1'b1;
				wr_log = idx_r_q;
				if (({1'b0, idx_l_q} + (AW + 1)'(2)) < {1'b0, idx_r_q}) begin
					state_d = deq_pkg::S_REV_RA;
				end else begin
					state_d = deq_pkg::S_DONE;
				end
			end
			deq_pkg::S_SRT_START: begin
				rd_en   = 1'b1;
				rd_log  = '0;
				state_d = deq_pkg::S_SRT_LOAD;
			end
			deq_pkg::S_SRT_LOAD: begin
				rd_en   = 1'b1;
				rd_log  = idx_l_q + AW'(1);
				state_d = deq_pkg::S_SRT_CMP;
			end
			deq_pkg::S_SRT_CMP: begin
				// The smaller word settles here; the larger one moves on in tmp_q.
				wr_en   = 1'b1;
				wr_log  = idx_l_q;
				wr_data = min_val;
				if ((idx_l_q + AW'(1)) == idx_r_q) begin
					state_d = deq_pkg::S_SRT_LAST;
				end else begin
					rd_en  = 1'b1;
					rd_log = idx_l_q + AW'(2);
				end
			end
			deq_pkg::S_SRT_LAST: begin
				wr_en  = 1'b1;
				wr_log = idx_r_q;
				if (idx_r_q == AW'(1)) begin
					state_d = deq_pkg::S_DONE;
				end else begin
					state_d = deq_pkg::S_SRT_START;
				end
			end
			deq_pkg::S_DONE: begin
				if (out_free) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= deq_pkg::S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			fix_front_q  <= 1'b0;
			fix_back_q   <= 1'b0;
			first_pass_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == deq_pkg::S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				deq_pkg::S_IDLE: begin
					if (accept) begin
						case (cmd)
							deq_pkg::CMD_PUSH_FRONT: begin
								if (!full) begin
									head_q  <= wr_addr;
									count_q <= count_q + CW'(1);
								end
							end
							deq_pkg::CMD_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							deq_pkg::CMD_POP_FRONT: begin
								if (!empty) begin
									head_q      <= head_next;
									count_q     <= count_q - CW'(1);
									fix_front_q <= two_plus;
								end
							end
							deq_pkg::CMD_POP_BACK: begin
								if (!empty) begin
									count_q    <= count_q - CW'(1);
									fix_back_q <= two_plus;
								end
							end
							deq_pkg::CMD_SORT: begin
								first_pass_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				deq_pkg::S_SRT_LAST: begin
					first_pass_q <= 1'b0;
				end
				deq_pkg::S_DONE: begin
					fix_front_q <= 1'b0;
					fix_back_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (accept) begin
					popped_q <= '0;
					status_q <= deq_pkg::STAT_OK;
					idx_l_q  <= '0;
					idx_r_q  <= count_q[AW-1:0] - AW'(1);
					case (cmd)
						deq_pkg::CMD_PUSH_FRONT: begin
							if (full) begin
								status_q <= deq_pkg::STAT_OVERFLOW;
							end else begin
								front_q <= push_value;
								if (empty) begin
									back_q <= push_value;
								end
							end
						end
						deq_pkg::CMD_PUSH_BACK: begin
							if (full) begin
								status_q <= deq_pkg::STAT_OVERFLOW;
							end else begin
								back_q <= push_value;
								if (empty) begin
									front_q <= push_value;
								end
							end
						end
						deq_pkg::CMD_POP_FRONT: begin
							if (empty) begin
								status_q <= deq_pkg::STAT_UNDERFLOW;
							end else begin
								popped_q <= front_q;
							end
						end
						deq_pkg::CMD_POP_BACK: begin
							if (empty) begin
								status_q <= deq_pkg::STAT_UNDERFLOW;
							end else begin
								popped_q <= back_q;
							end
						end
						deq_pkg::CMD_REVERSE: begin
							front_q <= back_q;
							back_q  <= front_q;
						end
						default: begin
						end
					endcase
				end
			end
			deq_pkg::S_REV_RB: begin
				tmp_q <= rd_data;
			end
			deq_pkg::S_REV_WB: begin
				idx_l_q <= idx_l_q + AW'(1);
				idx_r_q <= idx_r_q - AW'(1);
			end
			deq_pkg::S_SRT_START: begin
				idx_l_q <= '0;
			end
			deq_pkg::S_SRT_LOAD: begin
				tmp_q <= rd_data;
			end
			deq_pkg::S_SRT_CMP: begin
				tmp_q   <= max_val;
				idx_l_q <= idx_l_q + AW'(1);
				if (idx_l_q == '0) begin
					front_q <= min_val;
				end
			end
			deq_pkg::S_SRT_LAST: begin
				// The first pass carries the overall maximum to the back.
				if (first_pass_q) begin
					back_q <= tmp_q;
				end
				idx_r_q <= idx_r_q - AW'(1);
			end
			deq_pkg::S_DONE: begin
				if (fix_front_q) begin
					front_q <= rd_data;
				end
				if (fix_back_q) begin
					back_q <= rd_data;
				end
				if (out_free) begin
					m_tdata_q <= OUT_W'({back_sel, front_sel, empty, count_q, status_q,
						popped_q});
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. The read data holds while no read is requested.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the deque core: result consistency and the
// one-command-at-a-time handshake.
// ----------------------------------------------------------------------------
module deq_checker #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int IN_W  = ((3 + DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((3 * DATA_WIDTH + CW + 3 + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int DW = DATA_WIDTH;

	logic [DW-1:0] popped, front, back;
	logic [1:0]    status;
	logic [CW-1:0] count;
	logic          is_empty;

	assign popped   = m_tdata[DW-1:0];
	assign status   = m_tdata[DW +: 2];
	assign count    = m_tdata[DW + 2 +: CW];
	assign is_empty = m_tdata[DW + 2 + CW];
	assign front    = m_tdata[DW + 3 + CW +: DW];
	assign back     = m_tdata[2 * DW + 3 + CW +: DW];

	// A stalled result must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only one command is in flight.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted twice in a row");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (is_empty == (count == '0)) && (!is_empty || (front == '0 && back == '0)))
		else $error("empty flag or end words inconsistent with count");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == deq_pkg::STAT_OVERFLOW |-> count == CW'(DEPTH) && popped == '0)
		else $error("overflow reported while not full");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == deq_pkg::STAT_UNDERFLOW |-> is_empty && popped == '0)
		else $error("underflow reported while not empty");

endmodule

bind double_ended_queue_with_sort_core deq_checker #(
	.DEPTH(DEPTH),
	.DATA_WIDTH(DATA_WIDTH)
) u_deq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
